// ----- src/graph_component_search_core_macros.svh -----
// Assertion macros used by the graph component search sequencer.
`ifndef GRAPH_COMPONENT_SEARCH_CORE_MACROS_SVH
`define GRAPH_COMPONENT_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define GCS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define GCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/gcs_pkg.sv -----
// Package with constants, types and state encoding for the graph component search.
package gcs_pkg;

    // Default sizing of the graph storage.
    localparam int GCS_MAX_NODES  = 64;
    localparam int GCS_MAX_DEGREE = 8;

    // Fixed widths of the transaction fields.
    localparam int NODE_FW  = 6;
    localparam int COUNT_FW = 7;

    // Node count after reset.
    localparam logic [COUNT_FW-1:0] NODE_COUNT_RESET = 7'd64;

    // Operation codes of an input transaction.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_DEG,
        ST_EDGE,
        ST_POP,
        ST_FINISH
    } gcs_state_t;

    // One result transaction.
    typedef struct packed {
        logic [NODE_FW-1:0] group;
        logic [NODE_FW-1:0] member;
        logic               group_end;
        logic               run_end;
        logic               overflow;
    } gcs_result_t;

    // Result hand-off from the sequencer to the output register.
    typedef struct packed {
        logic        push;
        gcs_result_t data;
    } gcs_emit_t;

endpackage

// ----- src/gcs_ifs.sv -----
// Channel interfaces: input items, results and the node count write port.
interface gcs_item_if import gcs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [NODE_FW-1:0] node;
    logic [NODE_FW-1:0] neighbor;

    modport source (output valid, output operation, output node, output neighbor,
                    input ready);
    modport sink   (input valid, input operation, input node, input neighbor,
                    output ready);
endinterface

interface gcs_result_if import gcs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [NODE_FW-1:0] group;
    logic [NODE_FW-1:0] member;
    logic               group_end;
    logic               run_end;
    logic               overflow;

    modport source (output valid, output group, output member, output group_end,
                    output run_end, output overflow, input ready);
    modport sink   (input valid, input group, input member, input group_end,
                    input run_end, input overflow, output ready);
endinterface

interface gcs_cfg_if import gcs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [COUNT_FW-1:0] node_count;

    modport source (output valid, output node_count, input ready);
    modport sink   (input valid, input node_count, output ready);
endinterface

// ----- src/gcs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module gcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while the read is idle.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/gcs_seq.sv -----
// Sequencer that loads adjacency lists and walks them depth first.
`include "graph_component_search_core_macros.svh"

module gcs_seq import gcs_pkg::*; #(
    parameter int MAX_NODES  = GCS_MAX_NODES,
    parameter int MAX_DEGREE = GCS_MAX_DEGREE
) (
    input  logic                clk,
    input  logic                rst_n,
    gcs_item_if.sink            item,
    input  logic [COUNT_FW-1:0] node_count,
    input  logic                push_ok,
    output gcs_emit_t           emit
);

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int SP_W   = $clog2(MAX_NODES + 1);
    localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
    localparam int ADJ_D  = MAX_NODES * MAX_DEGREE;
    localparam int ADJ_AW = $clog2(ADJ_D);
    localparam int STK_W  = NODE_W + DEG_W;

    gcs_state_t state_reg, state_next;

    logic [NODE_W-1:0]  ld_node_reg, ld_node_next;
    logic [NODE_FW-1:0] ld_nb_reg, ld_nb_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   s_reg, s_next;
    logic [NODE_W-1:0]  top_node_reg, top_node_next;
    logic [DEG_W-1:0]   top_pos_reg, top_pos_next;
    logic [SP_W-1:0]    sp_reg, sp_next;
    logic [NODE_FW-1:0] group_reg, group_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [NODE_FW-1:0] pend_group_reg, pend_group_next;
    logic [NODE_FW-1:0] pend_member_reg, pend_member_next;
    logic               pend_end_reg, pend_end_next;
    logic               overflow_reg, overflow_next;
    logic [MAX_NODES-1:0] visited_reg, visited_next;
    logic [MAX_NODES-1:0] deg_valid_reg, deg_valid_next;

    // RAM ports.
    logic               deg_we, deg_re;
    logic [NODE_W-1:0]  deg_raddr;
    logic [DEG_W-1:0]   deg_wdata, deg_rdata;
    logic               adj_we, adj_re;
    logic [ADJ_AW-1:0]  adj_waddr, adj_raddr;
    logic [NODE_FW-1:0] adj_rdata;
    logic               stk_we, stk_re;
    logic [NODE_W-1:0]  stk_waddr, stk_raddr;
    logic [STK_W-1:0]   stk_wdata, stk_rdata;

    // Decoded conditions.
    logic               in_range;
    logic [CNT_W-1:0]   cnt_sat;
    logic               scan_done;
    logic [NODE_W-1:0]  s_idx;
    logic               s_seen;
    logic               slot_free;
    logic [DEG_W-1:0]   ld_deg;
    logic [DEG_W-1:0]   top_deg;
    logic               has_edge;
    logic               nb_new;
    logic [SP_W-1:0]    sp_dec;
    logic [SP_W-1:0]    sp_dec2;
    logic               emit_push;

    // Storage: degree counts, adjacency lists and the walk stack below its top.
    gcs_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (ld_node_reg),
        .wdata (deg_wdata),
        .re    (deg_re),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    gcs_ram #(.WIDTH(NODE_FW), .DEPTH(ADJ_D)) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (ld_nb_reg),
        .re    (adj_re),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    gcs_ram #(.WIDTH(STK_W), .DEPTH(MAX_NODES)) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Shared decode of the current step.
    assign in_range  = ({1'b0, item.node} < COUNT_FW'(MAX_NODES));
    assign cnt_sat   = (node_count > COUNT_FW'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                           : CNT_W'(node_count);
    assign scan_done = (s_reg == cnt_reg);
    assign s_idx     = s_reg[NODE_W-1:0];
    assign s_seen    = visited_reg[s_idx];
    assign slot_free = !pend_valid_reg || push_ok;
    assign ld_deg    = deg_valid_reg[ld_node_reg] ? deg_rdata : '0;
    assign top_deg   = deg_valid_reg[top_node_reg] ? deg_rdata : '0;
    assign has_edge  = (top_pos_reg < top_deg);
    assign nb_new    = ({1'b0, adj_rdata} < COUNT_FW'(cnt_reg))
                       && !visited_reg[adj_rdata[NODE_W-1:0]]
                       && (sp_reg < SP_W'(MAX_NODES));
    assign sp_dec    = sp_reg - SP_W'(1);
    assign sp_dec2   = sp_reg - SP_W'(2);

    // Address generation.
    assign deg_raddr = (state_reg == ST_IDLE) ? item.node[NODE_W-1:0] : top_node_reg;
    assign deg_wdata = ld_deg + DEG_W'(1);
    assign adj_waddr = ADJ_AW'(ld_node_reg) * ADJ_AW'(MAX_DEGREE) + ADJ_AW'(ld_deg);
    assign adj_raddr = ADJ_AW'(top_node_reg) * ADJ_AW'(MAX_DEGREE) + ADJ_AW'(top_pos_reg);
    assign stk_waddr = sp_dec[NODE_W-1:0];
    assign stk_raddr = sp_dec2[NODE_W-1:0];
    assign stk_wdata = {top_node_reg, top_pos_reg + DEG_W'(1)};

    // Result leaving the pending slot.
    assign emit.push           = emit_push;
    assign emit.data.group     = pend_group_reg;
    assign emit.data.member    = pend_member_reg;
    assign emit.data.group_end = pend_end_reg;
    assign emit.data.run_end   = (state_reg == ST_FINISH);
    assign emit.data.overflow  = overflow_reg;
    assign item.ready          = (state_reg == ST_IDLE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid && item.operation == OP_RUN)
                begin
                    state_next = ST_SCAN;
                end
                else if (item.valid && in_range)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FINISH;
                end
                else if (!s_seen && slot_free)
                begin
                    state_next = ST_DEG;
                end
            end
            ST_DEG:
            begin
                state_next = ST_EDGE;
            end
            ST_EDGE:
            begin
                if (has_edge)
                begin
                    if (!nb_new || slot_free)
                    begin
                        state_next = ST_DEG;
                    end
                end
                else if (sp_reg == SP_W'(1))
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                state_next = ST_DEG;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory controls for each state.
    always_comb
    begin
        ld_node_next     = ld_node_reg;
        ld_nb_next       = ld_nb_reg;
        cnt_next         = cnt_reg;
        s_next           = s_reg;
        top_node_next    = top_node_reg;
        top_pos_next     = top_pos_reg;
        sp_next          = sp_reg;
        group_next       = group_reg;
        pend_valid_next  = pend_valid_reg;
        pend_group_next  = pend_group_reg;
        pend_member_next = pend_member_reg;
        pend_end_next    = pend_end_reg;
        overflow_next    = overflow_reg;
        visited_next     = visited_reg;
        deg_valid_next   = deg_valid_reg;
        deg_we           = 1'b0;
        deg_re           = 1'b0;
        adj_we           = 1'b0;
        adj_re           = 1'b0;
        stk_we           = 1'b0;
        stk_re           = 1'b0;
        emit_push        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // The degree read is issued speculatively for a load.
                deg_re       = 1'b1;
                ld_node_next = item.node[NODE_W-1:0];
                ld_nb_next   = item.neighbor;
                if (item.valid && item.operation == OP_RUN)
                begin
                    cnt_next   = cnt_sat;
                    s_next     = '0;
                    group_next = '0;
                end
            end
            ST_LOAD:
            begin
                if (ld_deg >= DEG_W'(MAX_DEGREE))
                begin
                    overflow_next = 1'b1;
                end
                else
                begin
                    adj_we                      = 1'b1;
                    deg_we                      = 1'b1;
                    deg_valid_next[ld_node_reg] = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (!scan_done)
                begin
                    if (s_seen)
                    begin
                        s_next = s_reg + CNT_W'(1);
                    end
                    else if (slot_free)
                    begin
                        // A new group opens at this start node.
                        emit_push           = pend_valid_reg;
                        pend_valid_next     = 1'b1;
                        pend_group_next     = group_reg;
                        pend_member_next    = NODE_FW'(s_idx);
                        pend_end_next       = 1'b0;
                        visited_next[s_idx] = 1'b1;
                        top_node_next       = s_idx;
                        top_pos_next        = '0;
                        sp_next             = SP_W'(1);
                        s_next              = s_reg + CNT_W'(1);
                    end
                end
            end
            ST_DEG:
            begin
                deg_re = 1'b1;
                adj_re = 1'b1;
            end
            ST_EDGE:
            begin
                if (has_edge)
                begin
                    if (!nb_new)
                    begin
                        top_pos_next = top_pos_reg + DEG_W'(1);
                    end
                    else if (slot_free)
                    begin
                        // Descend: save the parent with its next position.
                        emit_push                            = pend_valid_reg;
                        pend_valid_next                      = 1'b1;
                        pend_group_next                      = group_reg;
                        pend_member_next                     = adj_rdata;
                        pend_end_next                        = 1'b0;
                        visited_next[adj_rdata[NODE_W-1:0]] = 1'b1;
                        stk_we                               = 1'b1;
                        top_node_next                        = adj_rdata[NODE_W-1:0];
                        top_pos_next                         = '0;
                        sp_next                              = sp_reg + SP_W'(1);
                    end
                end
                else if (sp_reg == SP_W'(1))
                begin
                    // The group is complete.
                    pend_end_next = 1'b1;
                    group_next    = group_reg + NODE_FW'(1);
                    sp_next       = '0;
                end
                else
                begin
                    stk_re  = 1'b1;
                    sp_next = sp_dec;
                end
            end
            ST_POP:
            begin
                top_node_next = stk_rdata[STK_W-1 -: NODE_W];
                top_pos_next  = stk_rdata[DEG_W-1:0];
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    emit_push       = pend_valid_reg;
                    pend_valid_next = 1'b0;
                    visited_next    = '0;
                    deg_valid_next  = '0;
                    overflow_next   = 1'b0;
                end
            end
            default:
            begin
                pend_valid_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sp_reg         <= '0;
            pend_valid_reg <= 1'b0;
            overflow_reg   <= 1'b0;
            visited_reg    <= '0;
            deg_valid_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            sp_reg         <= sp_next;
            pend_valid_reg <= pend_valid_next;
            overflow_reg   <= overflow_next;
            visited_reg    <= visited_next;
            deg_valid_reg  <= deg_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ld_node_reg     <= ld_node_next;
        ld_nb_reg       <= ld_nb_next;
        cnt_reg         <= cnt_next;
        s_reg           <= s_next;
        top_node_reg    <= top_node_next;
        top_pos_reg     <= top_pos_next;
        group_reg       <= group_next;
        pend_group_reg  <= pend_group_next;
        pend_member_reg <= pend_member_next;
        pend_end_reg    <= pend_end_next;
    end

    // Results leave only from states that close out a pending node.
    `GCS_ASSERT_IMPL(a_push_state, emit.push,
        (state_reg == ST_SCAN || state_reg == ST_EDGE || state_reg == ST_FINISH),
        "result pushed from a state that emits nothing")

    // A walk always has a node on the stack and one result held back.
    `GCS_ASSERT_IMPL(a_walk_live,
        (state_reg == ST_DEG || state_reg == ST_EDGE || state_reg == ST_POP),
        (pend_valid_reg && sp_reg != '0),
        "walk running without a stacked node or pending result")

    // The stack never grows past one entry per node.
    `GCS_ASSERT_IMPL(a_stack_bound, 1'b1, (sp_reg <= SP_W'(MAX_NODES)),
        "walk stack pointer beyond node capacity")

    // Leaving a run clears marks, lists and the overflow flag.
    `GCS_ASSERT_NEXT(a_run_clear, (state_reg == ST_FINISH && state_next == ST_IDLE),
        (visited_reg == '0 && deg_valid_reg == '0 && !overflow_reg && !pend_valid_reg),
        "state not cleared after a run")

endmodule

// ----- src/graph_component_search_core.sv -----
// Top level of the graph component search: config register, sequencer and result register.
//
// Usage. Three valid/ready channels. cfg writes node_count (1..64, larger values
// act as MAX_NODES); it is always ready. The user must see that it is written only
// while the block is idle; the block itself does not enforce this. item carries one
// operation per transaction. A load transaction (operation 0) appends neighbor to the
// list of node; a list that is already full drops the entry and sets the sticky
// overflow flag. A run transaction (operation 1) walks every node below node_count
// depth first and sends one result transaction per node: group, member, group_end
// on the last node of each group, run_end on the last node of the run, and the
// overflow flag. A run accepts the transaction, scans the nodes for start points,
// examines each list entry, sees for each node reached that its list is done, returns
// to a parent and finishes; the sequencer shares one degree/adjacency read per step.
// The item channel is not ready until the run ends and lists and marks are cleared.
// A result sits one node behind the walk so that its end flags are known, then goes
// to an output register; when the receiver stalls, the walk waits at the next node.
// After reset all lists are empty, no node is marked, overflow is clear and
// node_count is 64.
module graph_component_search_core import gcs_pkg::*; #(
    parameter int MAX_NODES  = GCS_MAX_NODES,
    parameter int MAX_DEGREE = GCS_MAX_DEGREE
) (
    input  logic        clk,
    input  logic        rst_n,
    gcs_cfg_if.sink     cfg,
    gcs_item_if.sink    item,
    gcs_result_if.source result
);

    logic [COUNT_FW-1:0] node_count_reg, node_count_next;
    logic                out_valid_reg, out_valid_next;
    gcs_result_t         out_data_reg;
    gcs_emit_t           emit;
    logic                push_ok;

    // Node count register.
    assign cfg.ready       = 1'b1;
    assign node_count_next = cfg.valid ? cfg.node_count : node_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
        end
        else
        begin
            node_count_reg <= node_count_next;
        end
    end

    gcs_seq #(
        .MAX_NODES  (MAX_NODES),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .node_count (node_count_reg),
        .push_ok    (push_ok),
        .emit       (emit)
    );

    // Output register: refilled in the cycle it is taken.
    assign push_ok = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.push)
        begin
            out_data_reg <= emit.data;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.group     = out_data_reg.group;
    assign result.member    = out_data_reg.member;
    assign result.group_end = out_data_reg.group_end;
    assign result.run_end   = out_data_reg.run_end;
    assign result.overflow  = out_data_reg.overflow;

endmodule
